[hw/rtl/tsg_pkg.sv]
// tsg_pkg: shared types and constants of the tape scale tick generator
// no dependencies
`timescale 1ns / 1ps

package tsg_pkg;

    localparam int DIV_W = 32;
    localparam logic signed [31:0] WRAP_VALUE = 32'sd36000;

    // configuration register indexes
    localparam logic [2:0] CFG_TAPE_MODE     = 3'd0;
    localparam logic [2:0] CFG_ORIENT_RIGHT  = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_X      = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_Y      = 3'd3;
    localparam logic [2:0] CFG_TAPE_LENGTH   = 3'd4;
    localparam logic [2:0] CFG_MINOR_INT     = 3'd5;
    localparam logic [2:0] CFG_MAJOR_INT     = 3'd6;
    localparam logic [2:0] CFG_UNITS_PER_PIX = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_M_DIV, ST_M_WAIT, ST_TS_DIV, ST_TS_WAIT, ST_TDP_DIV, ST_TDP_WAIT,
        ST_H_DIV, ST_H_WAIT, ST_MUL, ST_INIT1, ST_INIT2, ST_INIT3, ST_V_DIV, ST_V_WAIT,
        ST_V_FIX, ST_INDEX, ST_CHECK, ST_MOD_DIV, ST_MOD_WAIT, ST_EMIT, ST_FLUSH
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIV_M, OP_LATCH_M, OP_DIV_TS, OP_LATCH_TS, OP_DIV_TDP,
        OP_LATCH_TDP, OP_DIV_H, OP_LATCH_H, OP_MULS, OP_INIT1, OP_INIT2, OP_INIT3,
        OP_DIV_V, OP_LATCH_V, OP_FIX_V, OP_INDEX, OP_WRAP, OP_STEP, OP_DIV_MOD,
        OP_LATCH_MOD, OP_EMIT, OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic in_range;
        logic v_neg;
        logic out_free;
        logic n_full;
        logic compass;
    } dp_status_t;

endpackage

[hw/rtl/tsg_div.sv]
// tsg_div: unsigned restoring divider, one quotient bit per cycle
// depends on tsg_pkg
`timescale 1ns / 1ps

module tsg_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tsg_pkg::DIV_W-1:0] dividend,
    input  logic [tsg_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [tsg_pkg::DIV_W-1:0] quot,
    output logic [tsg_pkg::DIV_W-1:0] rem
);
    localparam int W  = tsg_pkg::DIV_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]  quot_reg, quot_next, rem_reg, rem_next, dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [W:0]    shifted;
    logic          ge;

    always_comb begin
        shifted   = {rem_reg, quot_reg[W-1]};
        ge        = shifted >= {1'b0, dsr_reg};
        rem_next  = ge ? W'(shifted - {1'b0, dsr_reg}) : shifted[W-1:0];
        quot_next = {quot_reg[W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[hw/rtl/tsg_ctrl.sv]
// tsg_ctrl: sequencing state machine of the tape scale tick generator
// depends on tsg_pkg
`timescale 1ns / 1ps

module tsg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tsg_pkg::dp_status_t status,
    output tsg_pkg::dp_cmd_t    cmd
);
    tsg_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = tsg_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            tsg_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = tsg_pkg::OP_LOAD;
                    state_next = tsg_pkg::ST_M_DIV;
                end
            end
            tsg_pkg::ST_M_DIV: begin
                cmd.op     = tsg_pkg::OP_DIV_M;
                state_next = tsg_pkg::ST_M_WAIT;
            end
            tsg_pkg::ST_M_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = tsg_pkg::OP_LATCH_M;
                    state_next = tsg_pkg::ST_TS_DIV;
                end
            end
            tsg_pkg::ST_TS_DIV: begin
                cmd.op     = tsg_pkg::OP_DIV_TS;
                state_next = tsg_pkg::ST_TS_WAIT;
            end
            tsg_pkg::ST_TS_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = tsg_pkg::OP_LATCH_TS;
                    state_next = tsg_pkg::ST_TDP_DIV;
                end
            end
            tsg_pkg::ST_TDP_DIV: begin
                cmd.op     = tsg_pkg::OP_DIV_TDP;
                state_next = tsg_pkg::ST_TDP_WAIT;
            end
            tsg_pkg::ST_TDP_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = tsg_pkg::OP_LATCH_TDP;
                    state_next = tsg_pkg::ST_H_DIV;
                end
            end
            tsg_pkg::ST_H_DIV: begin
                cmd.op     = tsg_pkg::OP_DIV_H;
                state_next = tsg_pkg::ST_H_WAIT;
            end
            tsg_pkg::ST_H_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = tsg_pkg::OP_LATCH_H;
                    state_next = tsg_pkg::ST_MUL;
                end
            end
            tsg_pkg::ST_MUL: begin
                cmd.op     = tsg_pkg::OP_MULS;
                state_next = tsg_pkg::ST_INIT1;
            end
            tsg_pkg::ST_INIT1: begin
                cmd.op     = tsg_pkg::OP_INIT1;
                state_next = tsg_pkg::ST_INIT2;
            end
            tsg_pkg::ST_INIT2: begin
                cmd.op     = tsg_pkg::OP_INIT2;
                state_next = tsg_pkg::ST_INIT3;
            end
            tsg_pkg::ST_INIT3: begin
                cmd.op     = tsg_pkg::OP_INIT3;
                state_next = status.compass ? tsg_pkg::ST_V_DIV : tsg_pkg::ST_INDEX;
            end
            tsg_pkg::ST_V_DIV: begin
                cmd.op     = tsg_pkg::OP_DIV_V;
                state_next = tsg_pkg::ST_V_WAIT;
            end
            tsg_pkg::ST_V_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = tsg_pkg::OP_LATCH_V;
                    state_next = tsg_pkg::ST_V_FIX;
                end
            end
            tsg_pkg::ST_V_FIX: begin
                cmd.op     = tsg_pkg::OP_FIX_V;
                state_next = tsg_pkg::ST_INDEX;
            end
            tsg_pkg::ST_INDEX: begin
                cmd.op     = tsg_pkg::OP_INDEX;
                state_next = tsg_pkg::ST_CHECK;
            end
            tsg_pkg::ST_CHECK: begin
                if (!status.in_range || status.n_full) begin
                    state_next = tsg_pkg::ST_FLUSH;
                end else if (!status.compass && status.v_neg) begin
                    cmd.op = tsg_pkg::OP_STEP;
                end else begin
                    cmd.op     = tsg_pkg::OP_WRAP;
                    state_next = tsg_pkg::ST_MOD_DIV;
                end
            end
            tsg_pkg::ST_MOD_DIV: begin
                cmd.op     = tsg_pkg::OP_DIV_MOD;
                state_next = tsg_pkg::ST_MOD_WAIT;
            end
            tsg_pkg::ST_MOD_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = tsg_pkg::OP_LATCH_MOD;
                    state_next = tsg_pkg::ST_EMIT;
                end
            end
            tsg_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = tsg_pkg::OP_EMIT;
                    state_next = tsg_pkg::ST_CHECK;
                end
            end
            tsg_pkg::ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.op     = tsg_pkg::OP_FLUSH;
                    state_next = tsg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/tsg_dp.sv]
// tsg_dp: configuration registers, tape arithmetic, segment staging and output register
// depends on tsg_pkg; drives the shared divider tsg_div
`timescale 1ns / 1ps

module tsg_dp #(
    parameter int MAX_SEGMENTS   = 32,
    parameter int MINOR_TICK_LEN = 5,
    parameter int MAJOR_TICK_LEN = 10,
    parameter int INDEX_LEN      = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_addr,
    input  logic [15:0]               cfg_wdata,
    input  logic [19:0]               shown_value,
    input  tsg_pkg::dp_cmd_t          cmd,
    output tsg_pkg::dp_status_t       status,
    output logic                      div_start,
    output logic [tsg_pkg::DIV_W-1:0] div_a,
    output logic [tsg_pkg::DIV_W-1:0] div_b,
    input  logic                      div_done,
    input  logic [tsg_pkg::DIV_W-1:0] div_q,
    input  logic [tsg_pkg::DIV_W-1:0] div_r,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [79:0]               m_tdata,
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);

    // configuration
    logic               tape_mode_reg, orient_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic [11:0]        len_reg;
    logic [15:0]        minor_reg, major_reg, upp_reg;
    logic [15:0]        minor_e, major_e, upp_e;

    // working values
    logic [19:0]        sv_reg, td_reg;
    logic [15:0]        m_reg;
    logic [31:0]        ts_reg, tdp_reg, hts_reg, hmin_reg, vq_reg;
    logic [11:0]        h_reg;
    logic signed [31:0] ref_reg, limit_reg, pos_reg, v_reg;
    logic               mj_reg;
    logic [NW-1:0]      n_reg;

    // staged segment and output register
    logic [15:0] pd_x1_reg, pd_y1_reg, pd_x2_reg, pd_y2_reg, pd_val_reg;
    logic        pd_idx_reg, pd_mj_reg;
    logic [79:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_last_reg, out_valid_reg;

    logic signed [31:0] ox32, oy32, half32, len32, ts_s, tdp_s, minor32;
    logic [31:0]        v_abs, ts_rnd, q_rnd;
    logic [43:0]        hts_prod;
    logic [47:0]        vq_prod;
    logic [31:0]        m_prod;
    logic [15:0]        w16, idx16, side_a, side_b, t_x1, t_y1, t_x2, t_y2;
    logic               out_free;

    always_comb begin
        minor_e = (minor_reg == 16'd0) ? 16'd1 : minor_reg;
        major_e = (major_reg == 16'd0) ? 16'd1 : major_reg;
        upp_e   = (upp_reg == 16'd0) ? 16'd1 : upp_reg;
        ox32    = 32'(ox_reg);
        oy32    = 32'(oy_reg);
        len32   = $signed({20'd0, len_reg});
        half32  = $signed({19'd0, (13'({1'b0, len_reg}) + 13'd1) >> 1});
        ts_s    = $signed(ts_reg);
        tdp_s   = $signed(tdp_reg);
        minor32 = $signed({16'd0, minor_e});
        v_abs   = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
        q_rnd   = (div_q + 32'd1) >> 1;
        ts_rnd  = (q_rnd == 32'd0) ? 32'd1 : q_rnd;
        m_prod  = div_q * {16'd0, minor_e};
        hts_prod = {32'd0, h_reg} * {12'd0, ts_reg};
        vq_prod  = {16'd0, div_q} * {32'd0, minor_e};
        out_free = !out_valid_reg || m_tready;
        // tick segment geometry
        w16    = mj_reg ? 16'(MAJOR_TICK_LEN) : 16'(MINOR_TICK_LEN);
        idx16  = 16'(INDEX_LEN);
        if (tape_mode_reg) begin
            t_x1 = pos_reg[15:0];
            t_y1 = oy_reg;
            t_x2 = pos_reg[15:0];
            t_y2 = orient_reg ? 16'(oy_reg + w16) : 16'(oy_reg - w16);
        end else begin
            t_x1 = ox_reg;
            t_y1 = pos_reg[15:0];
            t_x2 = orient_reg ? 16'(ox_reg + w16) : 16'(ox_reg - w16);
            t_y2 = pos_reg[15:0];
        end
        // index mark: starts two pixels off the axis on the side away from the ticks
        side_a = tape_mode_reg ? oy_reg : ox_reg;
        side_a = orient_reg ? 16'(side_a - 16'd2) : 16'(side_a + 16'd2);
        side_b = orient_reg ? 16'(side_a - idx16) : 16'(side_a + idx16);
    end

    // divider operands
    always_comb begin
        div_start = 1'b1;
        div_a     = '0;
        div_b     = 32'd1;
        case (cmd.op)
            tsg_pkg::OP_DIV_M: begin
                div_a = {16'd0, sv_reg[19:4]};
                div_b = {16'd0, minor_e};
            end
            tsg_pkg::OP_DIV_TS: begin
                div_a = {7'd0, minor_e, 9'd0};
                div_b = {16'd0, upp_e};
            end
            tsg_pkg::OP_DIV_TDP: begin
                div_a = {7'd0, td_reg, 5'd0};
                div_b = {16'd0, upp_e};
            end
            tsg_pkg::OP_DIV_H: begin
                div_a = {20'd0, len_reg};
                div_b = {ts_reg[30:0], 1'b0};
            end
            tsg_pkg::OP_DIV_V: begin
                div_a = v_abs;
                div_b = {16'd0, minor_e};
            end
            tsg_pkg::OP_DIV_MOD: begin
                div_a = v_abs;
                div_b = {16'd0, major_e};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tape_mode_reg <= 1'b0;
            orient_reg    <= 1'b0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            len_reg       <= 12'd200;
            minor_reg     <= 16'd10;
            major_reg     <= 16'd50;
            upp_reg       <= 16'd256;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tsg_pkg::CFG_TAPE_MODE:     tape_mode_reg <= cfg_wdata[0];
                tsg_pkg::CFG_ORIENT_RIGHT:  orient_reg    <= cfg_wdata[0];
                tsg_pkg::CFG_ORIGIN_X:      ox_reg        <= cfg_wdata;
                tsg_pkg::CFG_ORIGIN_Y:      oy_reg        <= cfg_wdata;
                tsg_pkg::CFG_TAPE_LENGTH:   len_reg       <= cfg_wdata[11:0];
                tsg_pkg::CFG_MINOR_INT:     minor_reg     <= cfg_wdata;
                tsg_pkg::CFG_MAJOR_INT:     major_reg     <= cfg_wdata;
                tsg_pkg::CFG_UNITS_PER_PIX: upp_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // arithmetic and segment staging
    always_ff @(posedge aclk) begin
        case (cmd.op)
            tsg_pkg::OP_LOAD:     sv_reg  <= shown_value;
            tsg_pkg::OP_LATCH_M:  m_reg   <= m_prod[15:0];
            tsg_pkg::OP_DIV_TS:   td_reg  <= sv_reg - {m_reg, 4'd0};
            tsg_pkg::OP_LATCH_TS: ts_reg  <= ts_rnd;
            tsg_pkg::OP_LATCH_TDP: tdp_reg <= q_rnd;
            tsg_pkg::OP_LATCH_H:  h_reg   <= div_q[11:0];
            tsg_pkg::OP_MULS: begin
                hts_reg   <= hts_prod[31:0];
                hmin_reg  <= {4'd0, 28'({16'd0, h_reg} * {12'd0, minor_e})};
                ref_reg   <= tape_mode_reg ? ox32 + half32 : oy32 - half32;
                limit_reg <= tape_mode_reg ? ox32 + len32 : oy32 - len32;
            end
            tsg_pkg::OP_INIT1: begin
                pos_reg <= tape_mode_reg ? ref_reg - $signed(hts_reg)
                                         : ref_reg + $signed(hts_reg);
                v_reg   <= $signed({16'd0, m_reg}) - $signed(hmin_reg);
            end
            tsg_pkg::OP_INIT2: begin
                pos_reg <= tape_mode_reg ? pos_reg - tdp_s : pos_reg + tdp_s;
                if (tape_mode_reg && v_reg <= 0) begin
                    v_reg <= v_reg + tsg_pkg::WRAP_VALUE;
                end
            end
            tsg_pkg::OP_INIT3: begin
                if (tdp_reg != 32'd0) begin
                    pos_reg <= tape_mode_reg ? pos_reg + ts_s : pos_reg - ts_s;
                    v_reg   <= v_reg + minor32;
                end
            end
            tsg_pkg::OP_LATCH_V:  vq_reg <= vq_prod[31:0];
            tsg_pkg::OP_FIX_V:    v_reg  <= v_reg[31] ? -$signed(vq_reg) : $signed(vq_reg);
            tsg_pkg::OP_INDEX: begin
                pd_x1_reg  <= tape_mode_reg ? ref_reg[15:0] : side_a;
                pd_y1_reg  <= tape_mode_reg ? side_a : ref_reg[15:0];
                pd_x2_reg  <= tape_mode_reg ? ref_reg[15:0] : side_b;
                pd_y2_reg  <= tape_mode_reg ? side_b : ref_reg[15:0];
                pd_idx_reg <= 1'b1;
                pd_mj_reg  <= 1'b0;
                pd_val_reg <= '0;
            end
            tsg_pkg::OP_STEP: begin
                pos_reg <= pos_reg - ts_s;
                v_reg   <= v_reg + minor32;
            end
            tsg_pkg::OP_WRAP: begin
                if (tape_mode_reg && v_reg > tsg_pkg::WRAP_VALUE) begin
                    v_reg <= v_reg - tsg_pkg::WRAP_VALUE;
                end
            end
            tsg_pkg::OP_LATCH_MOD: mj_reg <= (div_r == 32'd0);
            tsg_pkg::OP_EMIT: begin
                pd_x1_reg  <= t_x1;
                pd_y1_reg  <= t_y1;
                pd_x2_reg  <= t_x2;
                pd_y2_reg  <= t_y2;
                pd_idx_reg <= 1'b0;
                pd_mj_reg  <= mj_reg;
                pd_val_reg <= v_reg[15:0];
                pos_reg    <= tape_mode_reg ? pos_reg + ts_s : pos_reg - ts_s;
                v_reg      <= v_reg + minor32;
            end
            default: ;
        endcase
    end

    // segment count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == tsg_pkg::OP_EMIT || cmd.op == tsg_pkg::OP_FLUSH) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                tsg_pkg::OP_INDEX: n_reg <= NW'(1);
                tsg_pkg::OP_EMIT:  n_reg <= n_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == tsg_pkg::OP_EMIT || cmd.op == tsg_pkg::OP_FLUSH) begin
            out_data_reg <= {pd_val_reg, pd_y2_reg, pd_x2_reg, pd_y1_reg, pd_x1_reg};
            out_user_reg <= {pd_mj_reg, pd_idx_reg};
            out_last_reg <= (cmd.op == tsg_pkg::OP_FLUSH);
        end
    end

    always_comb begin
        status.div_done = div_done;
        status.in_range = tape_mode_reg ? (pos_reg < limit_reg) : (pos_reg > limit_reg);
        status.v_neg    = v_reg[31];
        status.out_free = out_free;
        status.n_full   = n_reg >= NW'(MAX_SEGMENTS);
        status.compass  = tape_mode_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

[hw/rtl/tape_scale_tick_generator.sv]
// tape_scale_tick_generator: top level, joins controller, datapath and divider
// depends on tsg_pkg, tsg_div, tsg_ctrl, tsg_dp
`timescale 1ns / 1ps

// usage
// - s_ channel: one displayed value per item (unsigned Q16.4 in s_tdata[19:0])
// - m_ channel: the line segments of the tape for that value, index mark first,
//   then one tick per minor interval; m_tlast marks the final segment of the run
// - cfg port: plain register writes, index 0..7 in work-list order, only while idle
// - one value is worked at a time; s_tready is high only when the previous run
//   has been fully handed to the output register
// - work per value: four divisions on the shared divider (a fifth in compass
//   mode) and setup steps; the index mark enters the output register when the
//   first tick is emitted, if a tick follows; each emitted tick then costs
//   one more division
// - a run holds up to MAX_SEGMENTS segments; the serial divider sets the pace
//   of the run, and the next value waits until the run is through
// - vertical ticks with negative value are skipped without a division
// - reset clears the controller, the divider and the output valid, and loads
//   the register defaults
// - a stalled receiver holds the output register; the next segment waits in a
//   staging register, so work pauses without loss
module tape_scale_tick_generator #(
    parameter int MAX_SEGMENTS   = 32,
    parameter int MINOR_TICK_LEN = 5,
    parameter int MAJOR_TICK_LEN = 10,
    parameter int INDEX_LEN      = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // shown_value[19:0], zero pad
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // seg_x1, seg_y1, seg_x2, seg_y2, tick_value
    output logic [1:0]  m_tuser,   // is_index, is_major
    output logic        m_tlast
);
    tsg_pkg::dp_cmd_t    cmd;
    tsg_pkg::dp_status_t status;

    logic                      div_start, div_busy, div_done;
    logic [tsg_pkg::DIV_W-1:0] div_a, div_b, div_q, div_r;

    // sequencing
    tsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // tape arithmetic and output register
    tsg_dp #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .MINOR_TICK_LEN (MINOR_TICK_LEN),
        .MAJOR_TICK_LEN (MAJOR_TICK_LEN),
        .INDEX_LEN      (INDEX_LEN)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .shown_value (s_tdata[19:0]),
        .cmd         (cmd),
        .status      (status),
        .div_start   (div_start),
        .div_a       (div_a),
        .div_b       (div_b),
        .div_done    (div_done),
        .div_q       (div_q),
        .div_r       (div_r),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // shared divider for all quotients and the major-tick remainder
    tsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // no new value taken while a division runs
    a_idle_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy) else $error("input ready during division");

    // a division result is signaled for a single cycle
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |=> !div_done) else $error("divider done held");

    // an accepted value closes the input until its run is through
    a_accept_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("input reopened early");

    // a segment is never both the index mark and a major tick
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1])) else $error("index flagged major");

endmodule

[tb/sv/tb_tape_scale_tick_generator.sv]
// tb_tape_scale_tick_generator: self-checking bench of the tape scale tick generator
// drives displayed values, predicts every segment of each run and checks the stream
// depends on tsg_pkg and tape_scale_tick_generator
`timescale 1ns / 1ps

module tb_tape_scale_tick_generator;

    localparam int  MAX_SEG    = 32;
    localparam int  MINOR_LEN  = 5;
    localparam int  MAJOR_LEN  = 10;
    localparam int  IDX_LEN    = 8;
    localparam int  WRAP       = 36000;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam int  DRAIN_CYCLES   = 400;
    localparam int  HOLD_CYCLES    = 4000;
    localparam int  RAND_ITEMS     = 400;

    // one expected segment, laid out like the output ports
    typedef struct packed {
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic        is_index;
        logic        is_major;
        logic [15:0] tick_value;
        logic        last;
    } segment_t;

    // directed row: either a register write or one displayed value
    typedef struct {
        bit          is_cfg;
        logic [2:0]  addr;
        logic [15:0] data;
        logic [19:0] value;
        bit          typed;      // index mark typed in by hand
        logic [15:0] tx1, ty1, tx2, ty2;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;     // seg_x1, seg_y1, seg_x2, seg_y2, tick_value
    logic [1:0]  m_tuser;     // is_index, is_major
    logic        m_tlast;

    // shadow copy of the registers
    logic        sh_mode;
    logic        sh_right;
    logic [15:0] sh_org_x;
    logic [15:0] sh_org_y;
    logic [11:0] sh_len;
    logic [15:0] sh_minor;
    logic [15:0] sh_major;
    logic [15:0] sh_upp;

    segment_t seg_expect_q[$];
    int       fail_count;
    int       idle_mode;      // 0: sender light, receiver heavy; 1: reversed; 2: none
    bit       hold_req;
    longint   cycle_count;

    tape_scale_tick_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_tape_scale_tick_generator NOT OK");
            $finish;
        end
    end

    // segments of one run, computed from the shadow registers
    function automatic void predict_tape_segments(input logic [19:0] shown);
        segment_t run_q[$];
        segment_t s;
        longint minor, major, upp, len, vint, m, td, ts, tdp, h, v, pos, ref_pt, lim, w, sgn;
        longint ox, oy;
        bit mj;
        begin
            minor = (sh_minor != 0) ? longint'(sh_minor) : 1;
            major = (sh_major != 0) ? longint'(sh_major) : 1;
            upp   = (sh_upp != 0) ? longint'(sh_upp) : 1;
            len   = longint'(sh_len);
            ox    = longint'($signed(sh_org_x));
            oy    = longint'($signed(sh_org_y));
            vint  = longint'(shown >> 4);
            m     = vint / minor * minor;
            td    = longint'(shown) - m * 16;
            ts    = (minor * 512 / upp + 1) / 2;
            if (ts < 1) ts = 1;
            tdp   = (td * 32 / upp + 1) / 2;
            h     = len / (2 * ts);
            v     = m - h * minor;
            sgn   = sh_right ? 1 : -1;
            s     = '0;
            if (!sh_mode) begin
                // vertical tape, index mark to the side of the axis
                ref_pt = oy - (len + 1) / 2;
                lim    = oy - len;
                pos    = ref_pt + h * ts + tdp;
                if (tdp != 0) begin
                    pos -= ts;
                    v   += minor;
                end
                s.x1 = 16'(ox - 2 * sgn);
                s.y1 = 16'(ref_pt);
                s.x2 = 16'(ox - 2 * sgn - IDX_LEN * sgn);
                s.y2 = 16'(ref_pt);
                s.is_index = 1'b1;
                run_q.push_back(s);
                for (; pos > lim && run_q.size() < MAX_SEG; pos -= ts) begin
                    if (v >= 0) begin
                        mj = (v % major) == 0;
                        w  = mj ? MAJOR_LEN : MINOR_LEN;
                        s  = '0;
                        s.x1 = 16'(ox);
                        s.y1 = 16'(pos);
                        s.x2 = 16'(ox + w * sgn);
                        s.y2 = 16'(pos);
                        s.is_major   = mj;
                        s.tick_value = 16'(v);
                        run_q.push_back(s);
                    end
                    v += minor;
                end
            end else begin
                // compass tape, value wraps at the full circle
                ref_pt = ox + (len + 1) / 2;
                lim    = ox + len;
                pos    = ref_pt - h * ts - tdp;
                if (v <= 0) v += WRAP;
                if (tdp != 0) begin
                    pos += ts;
                    v   += minor;
                end
                v = v / minor * minor;
                s.x1 = 16'(ref_pt);
                s.y1 = 16'(oy - 2 * sgn);
                s.x2 = 16'(ref_pt);
                s.y2 = 16'(oy - 2 * sgn - IDX_LEN * sgn);
                s.is_index = 1'b1;
                run_q.push_back(s);
                for (; pos < lim && run_q.size() < MAX_SEG; pos += ts) begin
                    if (v > WRAP) v -= WRAP;
                    mj = (v % major) == 0;
                    w  = mj ? MAJOR_LEN : MINOR_LEN;
                    s  = '0;
                    s.x1 = 16'(pos);
                    s.y1 = 16'(oy);
                    s.x2 = 16'(pos);
                    s.y2 = 16'(oy + w * sgn);
                    s.is_major   = mj;
                    s.tick_value = 16'(v);
                    run_q.push_back(s);
                    v += minor;
                end
            end
            run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i]) seg_expect_q.push_back(run_q[i]);
        end
    endfunction

    // one register write at the next falling edge; the caller lowers the enable
    task automatic write_reg(input logic [2:0] addr, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            tsg_pkg::CFG_TAPE_MODE:     sh_mode  = data[0];
            tsg_pkg::CFG_ORIENT_RIGHT:  sh_right = data[0];
            tsg_pkg::CFG_ORIGIN_X:      sh_org_x = data;
            tsg_pkg::CFG_ORIGIN_Y:      sh_org_y = data;
            tsg_pkg::CFG_TAPE_LENGTH:   sh_len   = data[11:0];
            tsg_pkg::CFG_MINOR_INT:     sh_minor = data;
            tsg_pkg::CFG_MAJOR_INT:     sh_major = data;
            tsg_pkg::CFG_UNITS_PER_PIX: sh_upp   = data;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender pauses until every expected segment is out and the block is idle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (seg_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // offer one value, with a random gap first depending on the idle mode
    task automatic send_value(input logic [19:0] value, input bit typed,
                              input logic [15:0] tx1, input logic [15:0] ty1,
                              input logic [15:0] tx2, input logic [15:0] ty2);
        int pct;
        int first;
        begin
            pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 66 : 0;
            if ($urandom_range(99) < pct) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6)) @(negedge aclk);
            end else begin
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, value};
            do @(posedge aclk); while (!s_tready);
            first = seg_expect_q.size();
            predict_tape_segments(value);
            if (typed) begin
                seg_expect_q[first].x1 = tx1;
                seg_expect_q[first].y1 = ty1;
                seg_expect_q[first].x2 = tx2;
                seg_expect_q[first].y2 = ty2;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int pct;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            pct = (idle_mode == 0) ? 66 : (idle_mode == 1) ? 22 : 0;
            m_tready <= ($urandom_range(99) >= pct);
        end
    end

    // result checker at the rising edge
    always @(posedge aclk) begin
        segment_t got;
        segment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                   m_tuser[0], m_tuser[1], m_tdata[79:64], m_tlast};
            if (seg_expect_q.size() == 0) begin
                $display("%0t: unexpected segment %h", $time, got);
                fail_count++;
            end else begin
                want = seg_expect_q.pop_front();
                if (got !== want) begin
                    $display("%0t: segment mismatch expected %h actual %h", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    // random register setting, biased toward the extremes
    task automatic write_random_config();
        logic [15:0] d;
        begin
            write_reg(tsg_pkg::CFG_TAPE_MODE, 16'($urandom_range(1)));
            write_reg(tsg_pkg::CFG_ORIENT_RIGHT, 16'($urandom_range(1)));
            case ($urandom_range(3))
                0: d = 16'h8000;
                1: d = 16'h7FFF;
                default: d = 16'($urandom);
            endcase
            write_reg(tsg_pkg::CFG_ORIGIN_X, d);
            case ($urandom_range(3))
                0: d = 16'h8000;
                1: d = 16'h7FFF;
                default: d = 16'($urandom);
            endcase
            write_reg(tsg_pkg::CFG_ORIGIN_Y, d);
            case ($urandom_range(5))
                0: d = 16'd0;
                1: d = 16'd1;
                2: d = 16'hFFFF;     // upper bits are dropped to 4095
                default: d = 16'($urandom_range(400));
            endcase
            write_reg(tsg_pkg::CFG_TAPE_LENGTH, d);
            case ($urandom_range(5))
                0: d = 16'd0;
                1: d = 16'd1;
                2: d = 16'hFFFF;
                default: d = 16'($urandom_range(60, 1));
            endcase
            write_reg(tsg_pkg::CFG_MINOR_INT, d);
            case ($urandom_range(5))
                0: d = 16'd0;
                1: d = 16'hFFFF;
                2: d = 16'd1;
                default: d = 16'($urandom_range(300, 1));
            endcase
            write_reg(tsg_pkg::CFG_MAJOR_INT, d);
            case ($urandom_range(6))
                0: d = 16'd0;
                1: d = 16'd1;
                2: d = 16'hFFFF;
                default: d = 16'($urandom_range(1024, 16));
            endcase
            write_reg(tsg_pkg::CFG_UNITS_PER_PIX, d);
            end_writes();
        end
    endtask

    dir_row_t dir_tab[$];

    task automatic add_item(input logic [19:0] v);
        dir_row_t r;
        r = '{default: '0};
        r.value = v;
        dir_tab.push_back(r);
    endtask

    task automatic add_cfg(input logic [2:0] a, input logic [15:0] d);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr   = a;
        r.data   = d;
        dir_tab.push_back(r);
    endtask

    initial begin
        dir_row_t r;
        bit in_cfg;
        logic [19:0] v;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        fail_count  = 0;
        idle_mode   = 0;
        hold_req    = 1'b0;
        cycle_count = 0;
        in_cfg      = 1'b0;
        // register defaults after reset
        sh_mode  = 1'b0;
        sh_right = 1'b0;
        sh_org_x = '0;
        sh_org_y = '0;
        sh_len   = 12'd200;
        sh_minor = 16'd10;
        sh_major = 16'd50;
        sh_upp   = 16'd256;

        // directed table: reset defaults, value extremes, then the open cases
        r = '{default: '0};
        r.value = 20'd0;
        r.typed = 1'b1;          // index mark after reset: x 2..10 at y = -100
        r.tx1 = 16'd2;
        r.ty1 = -16'sd100;
        r.tx2 = 16'd10;
        r.ty2 = -16'sd100;
        dir_tab.push_back(r);
        add_item(20'hFFFFF);
        add_item(20'd8);         // fractional offset, tick steps inward
        add_item(20'd165);
        add_item(20'd800);       // lands on a major tick
        // compass tape near zero: negative start wraps to 36000
        add_cfg(tsg_pkg::CFG_TAPE_MODE, 16'd1);
        add_cfg(tsg_pkg::CFG_ORIENT_RIGHT, 16'd1);
        add_item(20'd0);
        add_item(20'd40);
        add_item(20'(36000 * 16 - 3));
        add_item(20'hFFFFF);     // compass value beyond one turn
        // zero intervals and scale act as one, spacing below a pixel, overflow
        add_cfg(tsg_pkg::CFG_MINOR_INT, 16'd0);
        add_cfg(tsg_pkg::CFG_MAJOR_INT, 16'd0);
        add_cfg(tsg_pkg::CFG_UNITS_PER_PIX, 16'd0);
        add_item(20'd12345);
        add_cfg(tsg_pkg::CFG_UNITS_PER_PIX, 16'hFFFF);
        add_item(20'd777);
        add_cfg(tsg_pkg::CFG_TAPE_MODE, 16'd0);
        add_item(20'd5000);
        // zero length gives the index mark only
        add_cfg(tsg_pkg::CFG_TAPE_LENGTH, 16'd0);
        add_item(20'd100);
        // far origins wrap in the 16-bit coordinates
        add_cfg(tsg_pkg::CFG_TAPE_LENGTH, 16'd4095);
        add_cfg(tsg_pkg::CFG_ORIGIN_X, 16'h7FFF);
        add_cfg(tsg_pkg::CFG_ORIGIN_Y, 16'h8000);
        add_cfg(tsg_pkg::CFG_MINOR_INT, 16'hFFFF);
        add_cfg(tsg_pkg::CFG_MAJOR_INT, 16'hFFFF);
        add_cfg(tsg_pkg::CFG_UNITS_PER_PIX, 16'd1);
        add_item(20'hFFFFF);
        add_cfg(tsg_pkg::CFG_TAPE_MODE, 16'd1);
        add_item(20'd0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            if (r.is_cfg) begin
                if (!in_cfg) wait_idle();
                in_cfg = 1'b1;
                write_reg(r.addr, r.data);
            end else begin
                if (in_cfg) end_writes();
                in_cfg = 1'b0;
                send_value(r.value, r.typed, r.tx1, r.ty1, r.tx2, r.ty2);
            end
        end

        // random part: a new setting every 25 values
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_mode = (n < RAND_ITEMS / 3) ? 0 : (n < 2 * RAND_ITEMS / 3) ? 1 : 2;
            if (n % 25 == 0) begin
                wait_idle();
                write_random_config();
            end
            if (n == 60) hold_req = 1'b1;   // long receiver stall, sender keeps offering
            if (n == 200) wait_idle();
            case ($urandom_range(3))
                0: v = 20'($urandom);
                1: v = 20'($urandom_range(1600));
                2: v = 20'($urandom_range(36000 * 16 + 400, 36000 * 16 - 400));
                default: v = 20'hFFFFF ^ 20'($urandom_range(15));
            endcase
            send_value(v, 1'b0, '0, '0, '0, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (seg_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_tape_scale_tick_generator OK");
        end else begin
            $display("tb_tape_scale_tick_generator NOT OK");
        end
        $finish;
    end

endmodule
